[rtl/core/glyph_quad_text_layout_top_defines.svh]
// Assertion macros used by the checker file.
`ifndef GLYPH_QUAD_TEXT_LAYOUT_TOP_DEFINES_SVH
`define GLYPH_QUAD_TEXT_LAYOUT_TOP_DEFINES_SVH
// Implication checked at every clock edge outside reset.
`define GQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication whose consequent is checked at the following clock edge.
`define GQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[rtl/core/gqtl_pkg.sv]
// Shared types and constants of the glyph quad text layout block.
package gqtl_pkg;
  localparam logic [1:0] CmdLoad  = 2'd0;
  localparam logic [1:0] CmdBegin = 2'd1;
  localparam logic [1:0] CmdChar  = 2'd2;
  localparam logic [7:0] CodeTab     = 8'd9;
  localparam logic [7:0] CodeNewline = 8'd10;
  localparam logic [7:0] CodeSpace   = 8'd32;
  localparam logic [0:0] RegOriginX = 1'b0;
  localparam logic [0:0] RegOriginY = 1'b1;
  localparam int unsigned EntryW = 124;

  typedef struct packed {
    logic signed [11:0] ox;
    logic signed [11:0] oy;
    logic [11:0] w;
    logic [11:0] h;
    logic [11:0] adv;
    logic [15:0] tl;
    logic [15:0] tr;
    logic [15:0] tt;
    logic [15:0] tb;
  } glyph_t;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) begin
      return 16'sh7fff;
    end else if (v < -18'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction
endpackage

[rtl/core/glyph_quad_text_layout_top.sv]
// Top level of the glyph quad text layout block.
// One item is taken at a time. Load and begin complete in the idle state, and
// newline and space pass through the read and execute states. A visible glyph
// reads its table entry in the read and execute states and then puts out six
// vertex beats, one a cycle while the sink does not stall. Tab with a zero stop
// passes through the read and execute states; otherwise it runs a 17-step
// shift-subtract divider. The glyph table is a GlyphCount-entry RAM with a
// registered read; after reset a sweep over all GlyphCount entries clears it
// before the first item is accepted.
module glyph_quad_text_layout_top #(
  parameter int GlyphCount = 256,
  parameter int TabSpaces  = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         cmd_i,
  input  logic [7:0]         char_code_i,
  input  logic signed [11:0] glyph_offset_x_i,
  input  logic signed [11:0] glyph_offset_y_i,
  input  logic [11:0]        glyph_width_i,
  input  logic [11:0]        glyph_height_i,
  input  logic [11:0]        glyph_advance_i,
  input  logic [15:0]        tex_left_i,
  input  logic [15:0]        tex_right_i,
  input  logic [15:0]        tex_top_i,
  input  logic [15:0]        tex_bottom_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] vertex_x_o,
  output logic signed [15:0] vertex_y_o,
  output logic [15:0]        vertex_u_o,
  output logic [15:0]        vertex_v_o,
  output logic [15:0]        vertex_index_o,
  output logic               quad_last_o
);
  localparam int AddrW = $clog2(GlyphCount);

  typedef enum logic [2:0] {
    StClear, StIdle, StRead, StExec, StEmit, StTab
  } state_e;

  state_e state_q;
  logic [AddrW-1:0] clr_q;
  logic signed [15:0] org_x_q, org_y_q, pen_x_q, pen_y_q;
  logic [11:0] line_h_q;
  logic [15:0] vcnt_q;
  logic [1:0] cmd_q;
  logic [7:0] code_q;
  logic in_range_q;
  logic [2:0] vtx_q;
  gqtl_pkg::glyph_t g_q, rd_g, wr_g;
  logic signed [15:0] l_q, r_q, t_q, b_q;

  logic ram_we;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [gqtl_pkg::EntryW-1:0] ram_wdata, ram_rdata;
  logic accept, out_fire;
  logic div_start, div_done;
  logic [15:0] div_step, stop;
  logic signed [16:0] diff;
  logic [16:0] tab_dist;
  logic [7:0] ld_code;
  logic [7:0] rd_code;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_fire = out_valid_o && !out_stall_i;
  assign in_stall_o = (state_q != StIdle);
  assign ld_code = char_code_i;

  assign wr_g = '{ox: glyph_offset_x_i, oy: glyph_offset_y_i, w: glyph_width_i,
                  h: glyph_height_i, adv: glyph_advance_i, tl: tex_left_i,
                  tr: tex_right_i, tt: tex_top_i, tb: tex_bottom_i};
  assign ram_we = (state_q == StClear) ||
                  (accept && cmd_i == gqtl_pkg::CmdLoad && ({1'b0, ld_code} < 9'(GlyphCount)));
  assign ram_waddr = (state_q == StClear) ? clr_q : ld_code[AddrW-1:0];
  assign ram_wdata = (state_q == StClear) ? '0 : wr_g;
  assign rd_code = accept ? char_code_i : code_q;
  assign ram_raddr = (rd_code == gqtl_pkg::CodeTab || rd_code == gqtl_pkg::CodeSpace)
                     ? gqtl_pkg::CodeSpace[AddrW-1:0] : rd_code[AddrW-1:0];

  gqtl_ram #(.Width(gqtl_pkg::EntryW), .Depth(GlyphCount)) u_table (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(ram_wdata),
    .raddr_i(ram_raddr), .rdata_o(ram_rdata)
  );

  assign rd_g  = in_range_q ? gqtl_pkg::glyph_t'(ram_rdata) : '0;
  assign stop  = 16'({4'b0, rd_g.adv} * TabSpaces);
  assign diff  = 17'(pen_x_q) - 17'(org_x_q);
  assign tab_dist = diff[16] ? 17'(-diff) : 17'(diff);
  assign div_start = (state_q == StExec) && code_q == gqtl_pkg::CodeTab && stop != '0;

  gqtl_tabdiv u_div (
    .clk_i, .rst_ni, .start_i(div_start), .d_i(tab_dist), .s_i(stop),
    .done_o(div_done), .step_o(div_step)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear;
      clr_q <= '0;
      org_x_q <= '0;
      org_y_q <= '0;
      pen_x_q <= '0;
      pen_y_q <= '0;
      line_h_q <= '0;
      vcnt_q <= '0;
      vtx_q <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == gqtl_pkg::RegOriginX) begin
          org_x_q <= cfg_data_i;
        end else begin
          org_y_q <= cfg_data_i;
        end
      end
      case (state_q)
        StClear: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AddrW'(GlyphCount - 1)) begin
            state_q <= StIdle;
          end
        end
        StIdle: begin
          if (accept) begin
            case (cmd_i)
              gqtl_pkg::CmdLoad: begin
                if ({1'b0, ld_code} < 9'(GlyphCount) && glyph_height_i > line_h_q) begin
                  line_h_q <= glyph_height_i;
                end
              end
              gqtl_pkg::CmdBegin: begin
                pen_x_q <= org_x_q;
                pen_y_q <= org_y_q;
                vcnt_q <= '0;
              end
              gqtl_pkg::CmdChar: state_q <= StRead;
              default: ;
            endcase
          end
        end
        StRead: state_q <= StExec;
        StExec: begin
          g_q <= rd_g;
          state_q <= StIdle;
          if (code_q == gqtl_pkg::CodeTab) begin
            if (stop != '0) begin
              state_q <= StTab;
            end
          end else if (code_q == gqtl_pkg::CodeNewline) begin
            pen_y_q <= gqtl_pkg::sat16(18'(pen_y_q) - 18'(line_h_q));
            pen_x_q <= org_x_q;
          end else if (code_q == gqtl_pkg::CodeSpace) begin
            pen_x_q <= gqtl_pkg::sat16(18'(pen_x_q) + 18'(rd_g.adv));
          end else begin
            l_q <= gqtl_pkg::sat16(18'(pen_x_q) + 18'(rd_g.ox));
            r_q <= gqtl_pkg::sat16(18'(pen_x_q) + 18'(rd_g.ox) + 18'(rd_g.w));
            t_q <= gqtl_pkg::sat16(18'(pen_y_q) + 18'(rd_g.oy));
            b_q <= gqtl_pkg::sat16(18'(pen_y_q) + 18'(rd_g.oy) - 18'(rd_g.h));
            vtx_q <= '0;
            out_valid_o <= 1'b1;
            state_q <= StEmit;
          end
        end
        StTab: begin
          if (div_done) begin
            pen_x_q <= gqtl_pkg::sat16(18'(pen_x_q) + 18'(div_step));
            state_q <= StIdle;
          end
        end
        StEmit: begin
          if (out_fire) begin
            if (vcnt_q != 16'hffff) begin
              vcnt_q <= vcnt_q + 16'd1;
            end
            vtx_q <= vtx_q + 3'd1;
            if (vtx_q == 3'd5) begin
              out_valid_o <= 1'b0;
              pen_x_q <= gqtl_pkg::sat16(18'(pen_x_q) + 18'(g_q.adv));
              state_q <= StIdle;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
      code_q <= char_code_i;
      in_range_q <= ({1'b0, char_code_i} < 9'(GlyphCount));
    end
  end

  // Vertex order: top left, bottom right, bottom left, top left, top right, bottom right.
  always_comb begin
    case (vtx_q)
      3'd0, 3'd3: begin
        vertex_x_o = l_q; vertex_y_o = t_q; vertex_u_o = g_q.tl; vertex_v_o = g_q.tt;
      end
      3'd2: begin
        vertex_x_o = l_q; vertex_y_o = b_q; vertex_u_o = g_q.tl; vertex_v_o = g_q.tb;
      end
      3'd4: begin
        vertex_x_o = r_q; vertex_y_o = t_q; vertex_u_o = g_q.tr; vertex_v_o = g_q.tt;
      end
      default: begin
        vertex_x_o = r_q; vertex_y_o = b_q; vertex_u_o = g_q.tr; vertex_v_o = g_q.tb;
      end
    endcase
  end
  assign vertex_index_o = vcnt_q;
  assign quad_last_o = (vtx_q == 3'd5) && (cmd_q == gqtl_pkg::CmdChar);
endmodule

[rtl/core/gqtl_ram.sv]
// Generic single-port-write, registered-read RAM.
module gqtl_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[rtl/core/gqtl_tabdiv.sv]
// Restoring divider that computes the distance to the next tab stop.
module gqtl_tabdiv (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [16:0] d_i,
  input  logic [15:0] s_i,
  output logic        done_o,
  output logic [15:0] step_o
);
  logic [16:0] rem_q, rem_d, quo_q, quo_d;
  logic [15:0] s_q;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [17:0] trial;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q, quo_q[16]} - {2'b0, s_q};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = d_i;
      cnt_d  = 5'd17;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[17]) begin
        rem_d = trial[16:0];
        quo_d = {quo_q[15:0], 1'b1};
      end else begin
        rem_d = {rem_q[15:0], quo_q[16]};
        quo_d = {quo_q[15:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (start_i) begin
      s_q <= s_i;
    end
  end

  // Step is stop minus the remainder, so a pen at or right of the origin lands on the next stop.
  assign done_o = busy_q && (cnt_q == 5'd1);
  assign step_o = s_q - rem_d[15:0];
endmodule

[rtl/core/gqtl_checker.sv]
// Port-level checker for the glyph quad text layout block, with its bind.
`include "glyph_quad_text_layout_top_defines.svh"
module gqtl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] vertex_index_o,
  input logic        quad_last_o
);
  `GQ_ASSERT_IMPL(a_busy_out, clk_i, rst_ni, out_valid_o, in_stall_o)
  `GQ_ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(vertex_index_o))
  `GQ_ASSERT_NEXT(a_idx_up, clk_i, rst_ni, out_valid_o && !out_stall_i && !quad_last_o && vertex_index_o != 16'hffff, vertex_index_o == $past(vertex_index_o) + 16'd1)
  `GQ_ASSERT_NEXT(a_last_end, clk_i, rst_ni, out_valid_o && !out_stall_i && quad_last_o, !out_valid_o)
endmodule

bind glyph_quad_text_layout_top gqtl_checker u_gqtl_checker (.*);
